>>> rtl/assert_macros.svh
// Assertion macros used by aes128_block_cipher.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: label");

// Clocked property that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed: label");

`endif

>>> rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 package
// Types, constants and GF(2^8)/S-box functions shared by the cipher modules.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned BlockW    = 128;
  localparam int unsigned KeyRegW   = 64;
  localparam logic [7:0]  GfPoly    = 8'h1b;

  // Configuration register indexes.
  localparam logic RegKeyHigh = 1'b0;
  localparam logic RegKeyLow  = 1'b1;

  // Direction codes.
  localparam logic OpEncrypt = 1'b0;
  localparam logic OpDecrypt = 1'b1;

  typedef struct packed {
    logic        op;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_beat_t;

  // Round key set carried along the pipeline, one 128-bit key per round.
  typedef logic [NumRounds:0][BlockW-1:0] rkeys_t;

  // Forward S-box table.
  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Inverse S-box table.
  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Round constants for rounds 1 to 10.
  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    logic [7:0] r;
    r = {a[6:0], 1'b0};
    if (a[7]) begin
      r = r ^ GfPoly;
    end
    return r;
  endfunction

  // Byte at position p (0 is the most significant byte) of a state word.
  function automatic logic [7:0] get_byte(input logic [BlockW-1:0] s, input int p);
    return s[BlockW-1-8*p -: 8];
  endfunction

  // One forward MixColumns column; a is the column bytes in row order.
  function automatic logic [31:0] mix_col(input logic [31:0] a);
    logic [7:0] b [4];
    logic [7:0] o [4];
    for (int r = 0; r < 4; r++) begin
      b[r] = a[31-8*r -: 8];
    end
    for (int r = 0; r < 4; r++) begin
      o[r] = xtime(b[r]) ^ xtime(b[(r+1)%4]) ^ b[(r+1)%4] ^ b[(r+2)%4] ^ b[(r+3)%4];
    end
    return {o[0], o[1], o[2], o[3]};
  endfunction

  // One inverse MixColumns column: a pre-step onto the forward matrix.
  function automatic logic [31:0] inv_mix_col(input logic [31:0] a);
    logic [7:0] b [4];
    logic [7:0] u;
    logic [7:0] v;
    for (int r = 0; r < 4; r++) begin
      b[r] = a[31-8*r -: 8];
    end
    u = xtime(xtime(b[0] ^ b[2]));
    v = xtime(xtime(b[1] ^ b[3]));
    return mix_col({b[0] ^ u, b[1] ^ v, b[2] ^ u, b[3] ^ v});
  endfunction

endpackage

`default_nettype wire

>>> rtl/aes_key_round.sv
// ----------------------------------------------------------------------------
// AES key schedule stage
// Registers one round key step: derives round key n+1 from round key n.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_key_round #(
  parameter logic [7:0] Rcon = 8'h01
) (
  input  wire logic         clk_i,
  input  wire logic [127:0] key_i,
  output      logic [127:0] key_o
);

  logic [31:0] w0, w1, w2, w3, t;
  logic [127:0] key_d, key_q;

  // RotWord, SubWord and round constant on the last word.
  always_comb begin
    w0 = key_i[127:96];
    w1 = key_i[95:64];
    w2 = key_i[63:32];
    w3 = key_i[31:0];
    t  = {aes_pkg::SBOX[w3[23:16]] ^ Rcon, aes_pkg::SBOX[w3[15:8]],
          aes_pkg::SBOX[w3[7:0]], aes_pkg::SBOX[w3[31:24]]};
    key_d[127:96] = w0 ^ t;
    key_d[95:64]  = w1 ^ w0 ^ t;
    key_d[63:32]  = w2 ^ w1 ^ w0 ^ t;
    key_d[31:0]   = w3 ^ w2 ^ w1 ^ w0 ^ t;
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

`default_nettype wire

>>> rtl/aes_round.sv
// ----------------------------------------------------------------------------
// AES round stage
// One registered cipher round in either direction, with its valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_round #(
  parameter bit IsFinal = 1'b0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire logic                 op_i,
  input  wire logic [127:0]         state_i,
  input  wire logic [127:0]         key_i,
  input  wire aes_pkg::rkeys_t      rkeys_i,
  output      logic                 valid_o,
  output      logic                 op_o,
  output      logic [127:0]         state_o,
  output      aes_pkg::rkeys_t      rkeys_o
);

  logic [127:0] enc_sr, enc_mc, dec_sb, dec_ak, dec_mc, state_d;
  logic         valid_q;
  logic         op_q;
  logic [127:0] state_q;
  aes_pkg::rkeys_t rkeys_q;

  // Forward: SubBytes, ShiftRows, MixColumns, AddRoundKey.
  // Inverse: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        enc_sr[127-8*(4*c+r) -: 8] =
          aes_pkg::SBOX[aes_pkg::get_byte(state_i, 4*((c+r)%4)+r)];
        dec_sb[127-8*(4*c+r) -: 8] =
          aes_pkg::INV_SBOX[aes_pkg::get_byte(state_i, 4*((c+4-r)%4)+r)];
      end
    end
    dec_ak = dec_sb ^ key_i;
    for (int c = 0; c < 4; c++) begin
      enc_mc[127-32*c -: 32] = aes_pkg::mix_col(enc_sr[127-32*c -: 32]);
      dec_mc[127-32*c -: 32] = aes_pkg::inv_mix_col(dec_ak[127-32*c -: 32]);
    end
    if (op_i == aes_pkg::OpDecrypt) begin
      state_d = IsFinal ? dec_ak : dec_mc;
    end else begin
      state_d = (IsFinal ? enc_sr : enc_mc) ^ key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_i;
    state_q <= state_d;
    rkeys_q <= rkeys_i;
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;
  assign state_o = state_q;
  assign rkeys_o = rkeys_q;

endmodule

`default_nettype wire

>>> rtl/aes128_block_cipher.sv
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Pipelined AES-128 encrypt/decrypt, one block per cycle.
// ----------------------------------------------------------------------------
// Channel   Ports                               Direction
// config    cfg_we_i, cfg_idx_i, cfg_wdata_i     in
// command   start_i, busy_o, in_beat_i          in
// result    done_o, out_beat_o                  out
//
// A beat may be started every cycle; busy_o is always low.
// A beat passes through 11 key schedule stages, then 11
// round stages (initial key add plus ten rounds, the last without MixColumns).
// Reset clears the key registers and all valid bits.
// The receiver cannot stall, so the pipeline never stops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module aes128_block_cipher (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [63:0]        cfg_wdata_i,
  input  wire logic               start_i,
  output      logic               busy_o,
  input  wire aes_pkg::in_beat_t  in_beat_i,
  output      logic               done_o,
  output      aes_pkg::out_beat_t out_beat_o
);

  localparam int unsigned Nr = aes_pkg::NumRounds;

  logic [63:0] key_high_q, key_low_q;
  logic        accept;

  // Key schedule pipeline, one stage per round key.
  logic [Nr:0][127:0] ks_key;
  logic [Nr:0]        ks_valid_q;
  logic [Nr:0]        ks_op_q;
  logic [Nr:0][127:0] ks_blk_q;
  aes_pkg::rkeys_t    ks_rk_q [Nr+1];

  // Round pipeline.
  logic [Nr+1:0]        rv;
  logic [Nr+1:0]        rop;
  logic [Nr+1:0][127:0] rst_st;
  aes_pkg::rkeys_t      rrk [Nr+2];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Key registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aes_pkg::RegKeyHigh: key_high_q <= cfg_wdata_i;
        aes_pkg::RegKeyLow:  key_low_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage 0 captures the beat; the cipher key is round key 0.
  assign ks_key[0] = {key_high_q, key_low_q};

  for (genvar k = 0; k < Nr; k++) begin : g_ks
    aes_key_round #(.Rcon(aes_pkg::RCON[k])) u_key (
      .clk_i (clk_i),
      .key_i (ks_key[k]),
      .key_o (ks_key[k+1])
    );
  end

  // Valid, op, block and collected round keys ride with the key schedule.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ks_valid_q <= '0;
    end else begin
      ks_valid_q <= {ks_valid_q[Nr-1:0], accept};
    end
  end

  // Stage s picks up round key s-1 and passes the others along.
  always_ff @(posedge clk_i) begin
    ks_op_q[0]  <= in_beat_i.op;
    ks_blk_q[0] <= {in_beat_i.block_high, in_beat_i.block_low};
    ks_rk_q[0]  <= '0;
    for (int s = 1; s <= Nr; s++) begin
      ks_op_q[s]  <= ks_op_q[s-1];
      ks_blk_q[s] <= ks_blk_q[s-1];
      for (int i = 0; i <= Nr; i++) begin
        ks_rk_q[s][i] <= (i == s - 1) ? ks_key[s-1] : ks_rk_q[s-1][i];
      end
    end
  end

  // Full round key set entering the cipher rounds.
  always_comb begin
    rrk[0]     = ks_rk_q[Nr];
    rrk[0][Nr] = ks_key[Nr];
  end

  // Initial whitening: key 0 for encrypt, key 10 for decrypt.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv[0] <= 1'b0;
    end else begin
      rv[0] <= ks_valid_q[Nr];
    end
  end

  logic             w_op_q;
  logic [127:0]     w_st_q;
  aes_pkg::rkeys_t  w_rk_q;

  always_ff @(posedge clk_i) begin
    w_op_q <= ks_op_q[Nr];
    w_rk_q <= rrk[0];
    w_st_q <= ks_blk_q[Nr] ^ ((ks_op_q[Nr] == aes_pkg::OpDecrypt) ?
              rrk[0][Nr] : rrk[0][0]);
  end

  assign rop[0]    = w_op_q;
  assign rst_st[0] = w_st_q;
  assign rrk[1]    = w_rk_q;

  for (genvar r = 1; r <= Nr; r++) begin : g_rnd
    aes_round #(.IsFinal(r == Nr)) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (rv[r-1]),
      .op_i    (rop[r-1]),
      .state_i (rst_st[r-1]),
      .key_i   ((rop[r-1] == aes_pkg::OpDecrypt) ? rrk[r][Nr-r] : rrk[r][r]),
      .rkeys_i (rrk[r]),
      .valid_o (rv[r]),
      .op_o    (rop[r]),
      .state_o (rst_st[r]),
      .rkeys_o (rrk[r+1])
    );
  end

  assign rv[Nr+1]     = rv[Nr];
  assign rop[Nr+1]    = rop[Nr];
  assign rst_st[Nr+1] = rst_st[Nr];

  assign done_o                 = rv[Nr+1];
  assign out_beat_o.result_high = rst_st[Nr+1][127:64];
  assign out_beat_o.result_low  = rst_st[Nr+1][63:0];

  // A beat accepted reaches the output after the fixed pipeline depth.
  `ASSERT_CLK(a_latency, clk_i, rst_ni, accept |-> ##22 done_o)
  // No result appears without an earlier start.
  `ASSERT_CLK(a_no_spurious, clk_i, rst_ni, done_o |-> $past(start_i, 22))
  // The block never refuses a command.
  `ASSERT_ALWAYS(a_never_busy, clk_i, !busy_o)

endmodule

`default_nettype wire
